### design/bba_pkg.sv
// Shared types and codes for the buddy block allocator.
package bba_pkg;

  typedef enum logic [1:0] {
    KIND_FREE   = 2'd0,
    KIND_SPLIT  = 2'd1,
    KIND_ABSENT = 2'd2,
    KIND_OWNED  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_ARG   = 2'd3
  } status_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

endpackage

### design/bba_ram.sv
// Generic single write port, single read port RAM with registered read data.
module bba_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### design/buddy_block_allocator_core.sv
// Buddy block allocator core: a binary buddy tree of 2^TREE_LEVELS-1 nodes in one node RAM.
//
// The region of TOTAL_UNITS units is kept as a complete binary tree whose nodes (kind and
// owner id) live in a single RAM with one write and one registered read port; each step
// of the sequencer reads or writes at most one node, and that port sets the timing. After
// reset a clearing pass writes every node, during which no word is accepted. One request
// is worked on at a time. An allocate decodes the word, reads the candidate nodes of its
// level in turn and climbs from an absent candidate through its ancestors (runs of
// candidates under one occupied ancestor are skipped together), splits each level down
// from the free ancestor it finds and then finishes. A free scans the nodes in index order
// at one node per cycle, then merges level by level while the buddy is free. A rejected
// word goes from decode straight to its result. A finished result waits in the output
// register while the next word is accepted.
module buddy_block_allocator_core #(
  parameter int TOTAL_UNITS = 64,
  parameter int TREE_LEVELS = 5,
  parameter int OWNER_BITS  = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic [6:0] request_size_i,
  input  logic [7:0] owner_id_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [5:0] block_offset_o,
  output logic [6:0] block_size_o
);

  localparam int NodeCount = (1 << TREE_LEVELS) - 1;
  localparam int IW = TREE_LEVELS;
  localparam int DW = $clog2(TREE_LEVELS);
  localparam int UW = $clog2(TOTAL_UNITS + 1);
  localparam int RW = OWNER_BITS + 2;
  localparam logic [UW-1:0] TotalV = UW'(TOTAL_UNITS);
  localparam logic [IW-1:0] LastIdx = IW'(NodeCount - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_A_CAND, S_A_WAIT, S_A_SPLIT1, S_A_SPLIT2, S_A_OWN,
    S_F_SCAN, S_F_CHK, S_F_MWAIT, S_F_M2, S_F_M3, S_DONE
  } state_e;

  state_e                 state_q, state_d;
  logic                   req_q, req_d;
  logic [6:0]             size_q, size_d;
  logic [OWNER_BITS-1:0]  id_q, id_d;
  logic [DW-1:0]          d_q, d_d;
  logic [IW-1:0]          pos_q, pos_d;
  logic [IW-1:0]          cur_q, cur_d;
  logic [DW-1:0]          k_q, k_d;
  logic [IW-1:0]          anc_q, anc_d;
  logic [IW-1:0]          pick_q, pick_d;
  logic [IW-1:0]          scan_q, scan_d;
  logic                   rv_q, rv_d;
  logic [IW-1:0]          ridx_q, ridx_d;
  bba_pkg::status_e       st_q, st_d;
  logic                   out_valid_q, out_valid_d;
  logic [1:0]             status_q, status_d;
  logic [5:0]             off_q, off_d;
  logic [6:0]             bsz_q, bsz_d;

  logic                   we, re;
  logic [IW-1:0]          waddr, raddr;
  logic [RW-1:0]          wdata, rdata;
  bba_pkg::kind_e         rd_kind;
  logic [OWNER_BITS-1:0]  rd_owner;

  logic [OWNER_BITS+7:0]  id_wide;
  logic [OWNER_BITS-1:0]  id_in;
  logic [IW-1:0]          par, bud, first_idx, cand, skip_pos, hit_first;
  logic [DW-1:0]          lvl, hit_d;
  logic [UW-1:0]          sz;
  logic [IW+UW-1:0]       prod;
  logic [UW+6:0]          sz_ext;

  function automatic logic [DW-1:0] depth_of(input logic [IW-1:0] n);
    logic [DW-1:0] r;
    r = '0;
    for (int j = 1; j < TREE_LEVELS; j++) begin
      if (n >= IW'((1 << j) - 1)) begin
        r = DW'(j);
      end
    end
    return r;
  endfunction

  bba_ram #(
    .Width(RW),
    .Depth(NodeCount)
  ) u_nodes (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_kind  = bba_pkg::kind_e'(rdata[RW-1:OWNER_BITS]);
  assign rd_owner = rdata[OWNER_BITS-1:0];

  assign id_wide   = (OWNER_BITS + 8)'(owner_id_i);
  assign id_in     = id_wide[OWNER_BITS-1:0];
  assign par       = (cur_q - IW'(1)) >> 1;
  assign bud       = cur_q[0] ? cur_q + IW'(1) : cur_q - IW'(1);
  assign first_idx = (IW'(1) << d_q) - IW'(1);
  assign cand      = first_idx + pos_q;
  assign skip_pos  = ((pos_q >> k_q) + IW'(1)) << k_q;
  assign hit_d     = depth_of(ridx_q);
  assign hit_first = (IW'(1) << hit_d) - IW'(1);
  assign sz        = TotalV >> d_q;
  assign prod      = (IW + UW)'(pos_q) * (IW + UW)'(sz);
  assign sz_ext    = (UW + 7)'(sz);

  always_comb begin
    lvl = '0;
    for (int k = 1; k < TREE_LEVELS; k++) begin
      if (32'(TOTAL_UNITS >> k) >= 32'(size_q)) begin
        lvl = DW'(k);
      end
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    size_d      = size_q;
    id_d        = id_q;
    d_d         = d_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    k_d         = k_q;
    anc_d       = anc_q;
    pick_d      = pick_q;
    scan_d      = scan_q;
    rv_d        = rv_q;
    ridx_d      = ridx_q;
    st_d        = st_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    off_d       = off_q;
    bsz_d       = bsz_q;
    we          = 1'b0;
    waddr       = cur_q;
    wdata       = '0;
    re          = 1'b0;
    raddr       = cur_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        we     = 1'b1;
        waddr  = scan_q;
        wdata  = {(scan_q == '0) ? bba_pkg::KIND_FREE : bba_pkg::KIND_ABSENT,
                  {OWNER_BITS{1'b0}}};
        scan_d = scan_q + IW'(1);
        if (scan_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = req_type_i;
          size_d  = request_size_i;
          id_d    = id_in;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (id_q == '0) begin
          st_d    = bba_pkg::ST_BAD_ARG;
          state_d = S_DONE;
        end else if (req_q == bba_pkg::REQ_ALLOC) begin
          if (size_q == '0 || 32'(size_q) > 32'(TOTAL_UNITS)) begin
            st_d    = bba_pkg::ST_BAD_ARG;
            state_d = S_DONE;
          end else begin
            d_d     = lvl;
            pos_d   = '0;
            state_d = S_A_CAND;
          end
        end else begin
          scan_d  = '0;
          rv_d    = 1'b0;
          state_d = S_F_SCAN;
        end
      end
      S_A_CAND: begin
        if (pos_q >= (IW'(1) << d_q)) begin
          st_d    = bba_pkg::ST_NO_SPACE;
          state_d = S_DONE;
        end else begin
          re      = 1'b1;
          raddr   = cand;
          cur_d   = cand;
          k_d     = '0;
          state_d = S_A_WAIT;
        end
      end
      S_A_WAIT: begin
        case (rd_kind)
          bba_pkg::KIND_FREE: begin
            pick_d = cand;
            if (k_q == '0) begin
              state_d = S_A_OWN;
            end else begin
              anc_d   = cur_q;
              cur_d   = cand;
              state_d = S_A_SPLIT1;
            end
          end
          bba_pkg::KIND_ABSENT: begin
            if (cur_q == '0) begin
              pos_d   = skip_pos;
              state_d = S_A_CAND;
            end else begin
              re    = 1'b1;
              raddr = par;
              cur_d = par;
              k_d   = k_q + DW'(1);
            end
          end
          default: begin
            pos_d   = (k_q == '0) ? pos_q + IW'(1) : skip_pos;
            state_d = S_A_CAND;
          end
        endcase
      end
      S_A_SPLIT1: begin
        we      = 1'b1;
        waddr   = bud;
        wdata   = {bba_pkg::KIND_FREE, {OWNER_BITS{1'b0}}};
        state_d = S_A_SPLIT2;
      end
      S_A_SPLIT2: begin
        we      = 1'b1;
        waddr   = par;
        wdata   = {bba_pkg::KIND_SPLIT, {OWNER_BITS{1'b0}}};
        cur_d   = par;
        state_d = (par == anc_q) ? S_A_OWN : S_A_SPLIT1;
      end
      S_A_OWN: begin
        we      = 1'b1;
        waddr   = pick_q;
        wdata   = {bba_pkg::KIND_OWNED, id_q};
        st_d    = bba_pkg::ST_OK;
        state_d = S_DONE;
      end
      S_F_SCAN: begin
        if (rv_q && rd_kind == bba_pkg::KIND_OWNED && rd_owner == id_q) begin
          we      = 1'b1;
          waddr   = ridx_q;
          wdata   = {bba_pkg::KIND_FREE, {OWNER_BITS{1'b0}}};
          cur_d   = ridx_q;
          d_d     = hit_d;
          pos_d   = ridx_q - hit_first;
          rv_d    = 1'b0;
          st_d    = bba_pkg::ST_OK;
          state_d = S_F_CHK;
        end else if (rv_q && ridx_q == LastIdx) begin
          rv_d    = 1'b0;
          st_d    = bba_pkg::ST_NOT_FOUND;
          state_d = S_DONE;
        end else if (scan_q <= LastIdx) begin
          re     = 1'b1;
          raddr  = scan_q;
          rv_d   = 1'b1;
          ridx_d = scan_q;
          scan_d = scan_q + IW'(1);
        end else begin
          rv_d = 1'b0;
        end
      end
      S_F_CHK: begin
        if (cur_q == '0) begin
          state_d = S_DONE;
        end else begin
          re      = 1'b1;
          raddr   = bud;
          state_d = S_F_MWAIT;
        end
      end
      S_F_MWAIT: begin
        if (rd_kind == bba_pkg::KIND_FREE) begin
          we      = 1'b1;
          waddr   = cur_q;
          wdata   = {bba_pkg::KIND_ABSENT, {OWNER_BITS{1'b0}}};
          state_d = S_F_M2;
        end else begin
          state_d = S_DONE;
        end
      end
      S_F_M2: begin
        we      = 1'b1;
        waddr   = bud;
        wdata   = {bba_pkg::KIND_ABSENT, {OWNER_BITS{1'b0}}};
        state_d = S_F_M3;
      end
      S_F_M3: begin
        we      = 1'b1;
        waddr   = par;
        wdata   = {bba_pkg::KIND_FREE, {OWNER_BITS{1'b0}}};
        cur_d   = par;
        state_d = S_F_CHK;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          status_d    = st_q;
          if (st_q == bba_pkg::ST_OK) begin
            off_d = prod[5:0];
            bsz_d = sz_ext[6:0];
          end else begin
            off_d = '0;
            bsz_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      req_q       <= 1'b0;
      size_q      <= '0;
      id_q        <= '0;
      d_q         <= '0;
      pos_q       <= '0;
      cur_q       <= '0;
      k_q         <= '0;
      anc_q       <= '0;
      pick_q      <= '0;
      scan_q      <= '0;
      rv_q        <= 1'b0;
      ridx_q      <= '0;
      st_q        <= bba_pkg::ST_OK;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      off_q       <= '0;
      bsz_q       <= '0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      size_q      <= size_d;
      id_q        <= id_d;
      d_q         <= d_d;
      pos_q       <= pos_d;
      cur_q       <= cur_d;
      k_q         <= k_d;
      anc_q       <= anc_d;
      pick_q      <= pick_d;
      scan_q      <= scan_d;
      rv_q        <= rv_d;
      ridx_q      <= ridx_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      off_q       <= off_d;
      bsz_q       <= bsz_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign block_offset_o = off_q;
  assign block_size_o   = bsz_q;

endmodule
